[hw/rtl/s5u_pkg.sv]
// ----------------------------------------------------------------------------
// s5u_pkg: shared types and codes for the SOCKS5 UDP header parser
// Parse phases, result kinds, address kinds, error codes and the record that
// the front part hands to the back part through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package s5u_pkg;

  // Parse phase of the front part, one-hot.
  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_ADDR    = 7'b0000010,
    PH_DLEN    = 7'b0000100,
    PH_DOMAIN  = 7'b0001000,
    PH_PORT    = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_SKIP    = 7'b1000000
  } phase_t;

  // Result item kinds.
  localparam logic [1:0] KIND_ADDR    = 2'd0;
  localparam logic [1:0] KIND_DOMAIN  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_STATUS  = 2'd3;

  // Address kinds.
  localparam logic [1:0] AK_IPV4   = 2'd0;
  localparam logic [1:0] AK_DOMAIN = 2'd1;
  localparam logic [1:0] AK_IPV6   = 2'd2;

  // Address type codes on the wire.
  localparam logic [7:0] ATYP_IPV4   = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] ATYP_IPV6   = 8'h04;

  // Last offset of an address field.
  localparam logic [7:0] IPV4_LAST = 8'd3;
  localparam logic [7:0] IPV6_LAST = 8'd15;

  // Error codes.
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_SHORT    = 3'd1;
  localparam logic [2:0] ERR_RESERVED = 3'd2;
  localparam logic [2:0] ERR_FRAGMENT = 3'd3;
  localparam logic [2:0] ERR_TYPE     = 3'd4;
  localparam logic [2:0] ERR_EMPTY    = 3'd5;
  localparam logic [2:0] ERR_NUL      = 3'd6;

  // Check flag bit positions.
  localparam int FL_RESERVED = 0;
  localparam int FL_FRAGMENT = 1;
  localparam int FL_TYPE     = 2;
  localparam int FL_EMPTY    = 3;
  localparam int FL_NUL      = 4;

  // Queue depth and its pointer width.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Work record for one accepted byte: an optional tag and an optional status.
  typedef struct packed {
    logic        tag_valid;
    logic [1:0]  tag_kind;
    logic [7:0]  value;
    logic [7:0]  offset;
    logic [1:0]  address_kind;
    logic        stat_valid;
    logic [15:0] port;
    logic [2:0]  error_code;
  } op_t;

endpackage

`default_nettype wire

[hw/rtl/s5u_in_if.sv]
// ----------------------------------------------------------------------------
// s5u_in_if: byte stream channel
// Carries one datagram byte and its end-of-packet mark per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface s5u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/s5u_out_if.sv]
// ----------------------------------------------------------------------------
// s5u_out_if: result item channel
// Carries one tag or status item per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface s5u_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  value;
  logic [7:0]  offset;
  logic [1:0]  address_kind;
  logic [15:0] port;
  logic [2:0]  error_code;
  logic        end_mark;

  modport source (output valid, output kind, output value, output offset,
                  output address_kind, output port, output error_code,
                  output end_mark, input ready);
  modport sink   (input valid, input kind, input value, input offset,
                  input address_kind, input port, input error_code,
                  input end_mark, output ready);
endinterface

`default_nettype wire

[hw/rtl/s5u_front.sv]
// ----------------------------------------------------------------------------
// s5u_front: byte classifier
// Tracks the header parse phase and turns each accepted byte into a work
// record holding at most one tag and one status, pushed only when it holds either.
// ----------------------------------------------------------------------------
`default_nettype none

module s5u_front import s5u_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  s5u_in_if.sink    byte_in,
  input  wire logic full,
  output logic      push,
  output op_t       push_op
);

  phase_t      phase, phase_next;
  logic [1:0]  hdr_pos, hdr_pos_next;
  logic [1:0]  akind, akind_next;
  logic [7:0]  dlen, dlen_next;
  logic [7:0]  foff, foff_next;
  logic [15:0] port_val, port_val_next;
  logic [4:0]  flags, flags_next;
  logic [7:0]  b;
  logic        accept;
  logic [2:0]  err;

  assign byte_in.ready = !full;
  assign accept        = byte_in.valid && byte_in.ready;
  assign b             = byte_in.data_byte;

  always_comb begin
    phase_next    = phase;
    akind_next    = akind;
    dlen_next     = dlen;
    foff_next     = foff;
    port_val_next = port_val;
    flags_next    = flags;
    hdr_pos_next  = (hdr_pos == 2'd3) ? hdr_pos : 2'(hdr_pos + 2'd1);
    push_op              = '0;
    push_op.value        = b;

    unique case (phase)
      PH_HEADER: begin
        if (hdr_pos < 2'd2) begin
          if (b != 8'd0) flags_next[FL_RESERVED] = 1'b1;
        end else if (hdr_pos == 2'd2) begin
          if (b != 8'd0) flags_next[FL_FRAGMENT] = 1'b1;
        end else begin
          if (b == ATYP_IPV4) begin
            akind_next = AK_IPV4;
            phase_next = PH_ADDR;
          end else if (b == ATYP_DOMAIN) begin
            akind_next = AK_DOMAIN;
            phase_next = PH_DLEN;
          end else if (b == ATYP_IPV6) begin
            akind_next = AK_IPV6;
            phase_next = PH_ADDR;
          end else begin
            flags_next[FL_TYPE] = 1'b1;
          end
          if (flags_next[FL_TYPE:FL_RESERVED] != 3'd0) phase_next = PH_SKIP;
          foff_next = 8'd0;
        end
      end
      PH_ADDR: begin
        push_op.tag_valid = 1'b1;
        push_op.tag_kind  = KIND_ADDR;
        push_op.offset    = foff;
        if (foff >= ((akind == AK_IPV6) ? IPV6_LAST : IPV4_LAST)) begin
          foff_next  = 8'd0;
          phase_next = PH_PORT;
        end else begin
          foff_next = 8'(foff + 8'd1);
        end
      end
      PH_DLEN: begin
        push_op.tag_valid = 1'b1;
        push_op.tag_kind  = KIND_DOMAIN;
        dlen_next         = b;
        if (b == 8'd0) begin
          flags_next[FL_EMPTY] = 1'b1;
          phase_next           = PH_SKIP;
        end else begin
          foff_next  = 8'd1;
          phase_next = PH_DOMAIN;
        end
      end
      PH_DOMAIN: begin
        push_op.tag_valid = 1'b1;
        push_op.tag_kind  = KIND_DOMAIN;
        push_op.offset    = foff;
        if (b == 8'd0) flags_next[FL_NUL] = 1'b1;
        if (foff >= dlen) begin
          foff_next  = 8'd0;
          phase_next = PH_PORT;
        end else begin
          foff_next = 8'(foff + 8'd1);
        end
      end
      PH_PORT: begin
        if (foff == 8'd0) begin
          port_val_next = {b, 8'd0};
          foff_next     = 8'd1;
        end else begin
          port_val_next = {port_val[15:8], b};
          foff_next     = 8'd0;
          phase_next    = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        push_op.tag_valid = 1'b1;
        push_op.tag_kind  = KIND_PAYLOAD;
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase

    // Status uses the state as it stands after this byte.
    priority if (phase_next == PH_HEADER) err = ERR_SHORT;
    else if (flags_next[FL_RESERVED])     err = ERR_RESERVED;
    else if (flags_next[FL_FRAGMENT])     err = ERR_FRAGMENT;
    else if (flags_next[FL_TYPE])         err = ERR_TYPE;
    else if (flags_next[FL_EMPTY])        err = ERR_EMPTY;
    else if (phase_next != PH_PAYLOAD)    err = ERR_SHORT;
    else if (flags_next[FL_NUL])          err = ERR_NUL;
    else                                  err = ERR_OK;

    push_op.address_kind = akind_next;
    push_op.stat_valid   = byte_in.last_byte;
    push_op.error_code   = err;
    push_op.port         = (phase_next == PH_PAYLOAD && (err == ERR_OK || err == ERR_NUL))
                           ? port_val_next : 16'd0;
  end

  assign push = accept && (push_op.tag_valid || push_op.stat_valid);

  always_ff @(posedge clk) begin
    if (rst || (accept && byte_in.last_byte)) begin
      phase    <= PH_HEADER;
      hdr_pos  <= 2'd0;
      akind    <= AK_IPV4;
      dlen     <= 8'd0;
      foff     <= 8'd0;
      port_val <= 16'd0;
      flags    <= 5'd0;
    end else if (accept) begin
      phase    <= phase_next;
      hdr_pos  <= hdr_pos_next;
      akind    <= akind_next;
      dlen     <= dlen_next;
      foff     <= foff_next;
      port_val <= port_val_next;
      flags    <= flags_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/s5u_queue.sv]
// ----------------------------------------------------------------------------
// s5u_queue: work record queue
// A small first-in first-out buffer that decouples classification from
// item delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module s5u_queue import s5u_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire op_t  push_op,
  output logic      full,
  input  wire logic pop,
  output op_t       head_op,
  output logic      empty
);

  op_t                 entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign head_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      if (push && !pop)      count <= (QPTR_W+1)'(count + 1'b1);
      else if (pop && !push) count <= (QPTR_W+1)'(count - 1'b1);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/s5u_back.sv]
// ----------------------------------------------------------------------------
// s5u_back: item emitter
// Delivers the tag and then the status of the work record at the queue head.
// ----------------------------------------------------------------------------
`default_nettype none

module s5u_back import s5u_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire op_t   head_op,
  input  wire logic  empty,
  output logic       pop,
  s5u_out_if.source  item_out
);

  logic tag_done;
  logic emit_tag;
  logic taken;

  assign emit_tag = head_op.tag_valid && !tag_done;
  assign taken    = item_out.valid && item_out.ready;
  assign pop      = taken && !(emit_tag && head_op.stat_valid);

  assign item_out.valid        = !empty;
  assign item_out.kind         = emit_tag ? head_op.tag_kind : KIND_STATUS;
  assign item_out.value        = emit_tag ? head_op.value : 8'd0;
  assign item_out.offset       = emit_tag ? head_op.offset : 8'd0;
  assign item_out.address_kind = head_op.address_kind;
  assign item_out.port         = emit_tag ? 16'd0 : head_op.port;
  assign item_out.error_code   = emit_tag ? ERR_OK : head_op.error_code;
  assign item_out.end_mark     = !emit_tag;

  always_ff @(posedge clk) begin
    if (rst || pop) begin
      tag_done <= 1'b0;
    end else if (taken && emit_tag) begin
      tag_done <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/socks5_udp_header_parser.sv]
// ----------------------------------------------------------------------------
// socks5_udp_header_parser: streaming SOCKS5 UDP request header parser
// Checks the header, tags address, domain and payload bytes, and closes each
// datagram with a status item.
// ----------------------------------------------------------------------------
// Usage: datagram bytes enter on byte_in, one byte per transaction, with
// last_byte set on the final byte. Result items leave on item_out. Every
// address, domain-length, domain and payload byte yields one tag item; the
// header and port bytes yield none. The final byte additionally yields a
// status item carrying the error code and, when the port was reached, the
// big-endian destination port. Tags are tentative until that status.
// A tag or status is registered in the queue and reaches item_out from its
// head. Throughput: one byte per cycle while the queue is not full; a final
// byte that also carries a tag yields two output items, which the four-entry
// queue absorbs. When item_out stalls, the queue fills and byte_in.ready
// drops only once four work records wait. A synchronous reset empties the
// queue and returns the parser to the start of a datagram; the next byte is
// treated as the first reserved byte.
// ----------------------------------------------------------------------------
`default_nettype none

module socks5_udp_header_parser import s5u_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  s5u_in_if.sink    byte_in,
  s5u_out_if.source item_out
);

  // Front to queue.
  logic push;
  op_t  push_op;
  logic full;

  // Queue to back.
  logic pop;
  op_t  head_op;
  logic empty;

  // The front classifies each accepted byte against the parse phase.
  s5u_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .full    (full),
    .push    (push),
    .push_op (push_op)
  );

  // The queue lets the front keep taking bytes while the receiver stalls.
  s5u_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .head_op (head_op),
    .empty   (empty)
  );

  // The back splits each record into its tag and status transactions.
  s5u_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_op  (head_op),
    .empty    (empty),
    .pop      (pop),
    .item_out (item_out)
  );

endmodule

`default_nettype wire
